// ===== hdl/descent_phase_sequencer_defines.svh =====
// Assertion macros for the descent phase sequencer.
`ifndef DESCENT_PHASE_SEQUENCER_DEFINES_SVH
`define DESCENT_PHASE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define DPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int ALT_W   = 20;
   localparam int THR_W   = 19;
   localparam int MS_W    = 32;
   localparam int PHASE_W = 3;
   localparam int ACT_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FORCE   = 2'd2;

   localparam logic [PHASE_W-1:0] PH_PRELAUNCH = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ASCENT    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_APOGEE    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CHUTE     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_LANDED    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_ALT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_APOGEE_ALT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APOGEE_DROP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUTE_ALT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_ALT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAND_ALT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_MS   = 3'd6;

   localparam logic [THR_W-1:0]        RST_LAUNCH_ALT  = 19'd2000;
   localparam logic [THR_W-1:0]        RST_APOGEE_ALT  = 19'd67000;
   localparam logic [THR_W-1:0]        RST_APOGEE_DROP = 19'd2000;
   localparam logic signed [ALT_W-1:0] RST_CHUTE_ALT   = 20'sd41000;
   localparam logic signed [ALT_W-1:0] RST_RELEASE_ALT = 20'sd31000;
   localparam logic signed [ALT_W-1:0] RST_LAND_ALT    = 20'sd500;
   localparam logic [MS_W-1:0]         RST_CAMERA_MS   = 32'd20000;
   localparam logic signed [ALT_W-1:0] ALT_MIN         = 20'sh80000;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } dps_cmd_type;

   typedef struct packed {
      logic is_eval;
      logic scan_last;
      logic out_free;
   } dps_stat_type;

endpackage

// ===== hdl/dps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: accept, window scan, commit of one word at a time.
// ----------------------------------------------------------------------------
module dps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dps_pkg::dps_stat_type stat,
   output dps_pkg::dps_cmd_type  cmd
);
   import dps_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PREP   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = req_ready && req_valid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = stat.is_eval ? ST_SCAN : ST_COMMIT;
         end
         ST_SCAN: begin
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/dps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_datapath
// Sample window, closest-to-mean search, phase state and result register.
// ----------------------------------------------------------------------------
module dps_datapath #(
   parameter int WINDOW = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dps_pkg::dps_cmd_type                  cmd,
   output dps_pkg::dps_stat_type                 stat,
   input  logic [dps_pkg::ACT_W-1:0]             req_action,
   input  logic signed [dps_pkg::ALT_W-1:0]      req_altitude_cm,
   input  logic [dps_pkg::MS_W-1:0]              req_now_ms,
   input  logic [dps_pkg::PHASE_W-1:0]           req_forced_phase,
   input  logic                                  csr_we,
   input  logic [dps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dps_pkg::CSR_DAT_W-1:0]         csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dps_pkg::PHASE_W-1:0]           rsp_phase,
   output logic                                  rsp_evaluated,
   output logic signed [dps_pkg::ALT_W-1:0]      rsp_chosen_cm,
   output logic signed [dps_pkg::ALT_W-1:0]      rsp_peak_cm,
   output logic                                  rsp_deploy_chute,
   output logic                                  rsp_release_payload,
   output logic                                  rsp_toggle_camera,
   output logic                                  rsp_payload_off,
   output logic                                  rsp_stop_telemetry,
   output logic                                  rsp_buzz
);
   import dps_pkg::*;

   localparam int TW = ALT_W + $clog2(WINDOW);
   localparam int DW = TW + 2;
   localparam int CW = $clog2(WINDOW + 1);
   localparam int AW = $clog2(WINDOW);
   localparam logic signed [DW-1:0] WIN_S = DW'(WINDOW);
   localparam logic [CW-1:0]        WIN_C = CW'(WINDOW);
   localparam logic [AW-1:0]        LAST_A = AW'(WINDOW - 1);

   // latched word
   logic [ACT_W-1:0]        act_ff;
   logic signed [ALT_W-1:0] alt_ff;
   logic [MS_W-1:0]         now_ff;
   logic [PHASE_W-1:0]      fph_ff;

   // settings
   logic [THR_W-1:0]        launch_ff, apogee_ff, drop_ff;
   logic signed [ALT_W-1:0] chute_ff, release_ff, land_ff;
   logic [MS_W-1:0]         cam_ms_ff;

   // flight state
   logic signed [ALT_W-1:0] mem_ff [WINDOW];
   logic [CW-1:0]           count_ff, count_in;
   logic signed [TW-1:0]    total_ff, total_in;
   logic signed [ALT_W-1:0] peak_ff, peak_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic                    cam_run_ff, cam_run_in;
   logic [MS_W-1:0]         rel_time_ff, rel_time_in;
   logic                    land_rep_ff, land_rep_in;

   // search
   logic [AW-1:0]           ptr_ff;
   logic signed [ALT_W-1:0] rd_data_ff;
   logic                    rd_vld_ff, rd_first_ff;
   logic signed [ALT_W-1:0] best_ff;
   logic [DW-1:0]           best_d_ff;
   logic signed [DW-1:0]    dev;
   logic [DW-1:0]           abs_dev;
   logic                    take;

   // result
   logic                    rsp_valid_ff;
   logic [PHASE_W-1:0]      rsp_phase_ff;
   logic                    rsp_eval_ff;
   logic signed [ALT_W-1:0] rsp_chosen_ff, rsp_peak_ff;
   logic                    rsp_chute_ff, rsp_rel_ff, rsp_cam_ff;
   logic                    rsp_poff_ff, rsp_stopt_ff, rsp_buzz_ff;

   // commit logic
   logic                    is_sample, win_full;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [ALT_W-1:0] chosen;
   logic                    eval_w, chute_w, rel_w, cam_w, poff_w, stopt_w, buzz_w;
   logic signed [ALT_W:0]   c21;
   logic signed [ALT_W+1:0] drop_diff;
   logic [MS_W-1:0]         elapsed;

   assign is_sample = (act_ff == ACT_SAMPLE);
   assign win_full  = (count_ff >= WIN_C);

   assign stat.is_eval   = is_sample && win_full;
   assign stat.scan_last = (ptr_ff == LAST_A);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // |WINDOW*x - total|
   assign dev     = DW'(rd_data_ff) * WIN_S - DW'(total_ff);
   assign abs_dev = dev[DW-1] ? DW'(-dev) : DW'(dev);
   assign take    = rd_first_ff || (abs_dev < best_d_ff);

   assign chosen    = best_ff;
   assign c21       = (ALT_W+1)'(chosen);
   assign drop_diff = (ALT_W+2)'(peak_in) - (ALT_W+2)'(chosen);
   assign elapsed   = now_ff - rel_time_ff;

   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      peak_in     = peak_ff;
      phase_in    = phase_ff;
      cam_run_in  = cam_run_ff;
      rel_time_in = rel_time_ff;
      land_rep_in = land_rep_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[AW-1:0];
      eval_w      = 1'b0;
      chute_w     = 1'b0;
      rel_w       = 1'b0;
      cam_w       = 1'b0;
      poff_w      = 1'b0;
      stopt_w     = 1'b0;
      buzz_w      = 1'b0;
      unique case (act_ff)
         ACT_RESTART: begin
            phase_in   = PH_PRELAUNCH;
            cam_run_in = 1'b0;
         end
         ACT_FORCE: begin
            if (fph_ff <= PH_LANDED) phase_in = fph_ff;
         end
         ACT_SAMPLE: begin
            if (alt_ff >= peak_ff) peak_in = alt_ff;
            wr_en = 1'b1;
            if (win_full) begin
               eval_w   = 1'b1;
               wr_addr  = '0;
               count_in = CW'(1);
               total_in = TW'(alt_ff);
               unique case (phase_ff)
                  PH_PRELAUNCH: begin
                     if (c21 > $signed({2'b00, launch_ff})) phase_in = PH_ASCENT;
                  end
                  PH_ASCENT: begin
                     if (c21 >= $signed({2'b00, apogee_ff}) ||
                         drop_diff >= $signed({3'b000, drop_ff}))
                        phase_in = PH_APOGEE;
                  end
                  PH_APOGEE: begin
                     if (chosen <= chute_ff) begin
                        phase_in = PH_CHUTE;
                        chute_w  = 1'b1;
                     end
                  end
                  PH_CHUTE: begin
                     if (chosen <= release_ff) begin
                        phase_in    = PH_PAYLOAD;
                        rel_w       = 1'b1;
                        cam_w       = 1'b1;
                        rel_time_in = now_ff;
                        cam_run_in  = 1'b1;
                     end
                  end
                  PH_PAYLOAD: begin
                     if (cam_run_ff && (elapsed > cam_ms_ff)) begin
                        cam_w      = 1'b1;
                        cam_run_in = 1'b0;
                     end
                     if (chosen <= land_ff) begin
                        phase_in    = PH_LANDED;
                        poff_w      = 1'b1;
                        land_rep_in = 1'b0;
                     end
                  end
                  PH_LANDED: begin
                     if (!land_rep_ff) begin
                        stopt_w     = 1'b1;
                        land_rep_in = 1'b1;
                     end
                     buzz_w = 1'b1;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end else begin
               count_in = count_ff + CW'(1);
               total_in = total_ff + TW'(alt_ff);
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // word capture and window store
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         alt_ff <= req_altitude_cm;
         now_ff <= req_now_ms;
         fph_ff <= req_forced_phase;
      end
      if (cmd.commit && wr_en) begin
         mem_ff[wr_addr] <= alt_ff;
      end
      if (cmd.scan) begin
         rd_data_ff  <= mem_ff[ptr_ff];
         rd_first_ff <= (ptr_ff == '0);
      end
      if (rd_vld_ff && take) begin
         best_ff   <= rd_data_ff;
         best_d_ff <= abs_dev;
      end
      if (cmd.commit) begin
         rsp_phase_ff  <= phase_in;
         rsp_eval_ff   <= eval_w;
         rsp_chosen_ff <= eval_w ? chosen : '0;
         rsp_peak_ff   <= peak_in;
         rsp_chute_ff  <= chute_w;
         rsp_rel_ff    <= rel_w;
         rsp_cam_ff    <= cam_w;
         rsp_poff_ff   <= poff_w;
         rsp_stopt_ff  <= stopt_w;
         rsp_buzz_ff   <= buzz_w;
      end
   end

   // control and flight state
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff    <= RST_LAUNCH_ALT;
         apogee_ff    <= RST_APOGEE_ALT;
         drop_ff      <= RST_APOGEE_DROP;
         chute_ff     <= RST_CHUTE_ALT;
         release_ff   <= RST_RELEASE_ALT;
         land_ff      <= RST_LAND_ALT;
         cam_ms_ff    <= RST_CAMERA_MS;
         count_ff     <= '0;
         total_ff     <= '0;
         peak_ff      <= ALT_MIN;
         phase_ff     <= PH_PRELAUNCH;
         cam_run_ff   <= 1'b0;
         rel_time_ff  <= '0;
         land_rep_ff  <= 1'b0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LAUNCH_ALT:  launch_ff  <= csr_wdata[THR_W-1:0];
               CSR_APOGEE_ALT:  apogee_ff  <= csr_wdata[THR_W-1:0];
               CSR_APOGEE_DROP: drop_ff    <= csr_wdata[THR_W-1:0];
               CSR_CHUTE_ALT:   chute_ff   <= csr_wdata[ALT_W-1:0];
               CSR_RELEASE_ALT: release_ff <= csr_wdata[ALT_W-1:0];
               CSR_LAND_ALT:    land_ff    <= csr_wdata[ALT_W-1:0];
               CSR_CAMERA_MS:   cam_ms_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         rd_vld_ff <= cmd.scan;
         if (cmd.load) begin
            ptr_ff <= '0;
         end else if (cmd.scan) begin
            ptr_ff <= ptr_ff + AW'(1);
         end
         if (cmd.commit) begin
            count_ff    <= count_in;
            total_ff    <= total_in;
            peak_ff     <= peak_in;
            phase_ff    <= phase_in;
            cam_run_ff  <= cam_run_in;
            rel_time_ff <= rel_time_in;
            land_rep_ff <= land_rep_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_evaluated       = rsp_eval_ff;
   assign rsp_chosen_cm       = rsp_chosen_ff;
   assign rsp_peak_cm         = rsp_peak_ff;
   assign rsp_deploy_chute    = rsp_chute_ff;
   assign rsp_release_payload = rsp_rel_ff;
   assign rsp_toggle_camera   = rsp_cam_ff;
   assign rsp_payload_off     = rsp_poff_ff;
   assign rsp_stop_telemetry  = rsp_stopt_ff;
   assign rsp_buzz            = rsp_buzz_ff;

endmodule

// ===== hdl/descent_phase_sequencer.sv =====
`timescale 1ns / 1ps
`include "descent_phase_sequencer_defines.svh"
// ----------------------------------------------------------------------------
// descent_phase_sequencer
// Altitude window filter and flight phase sequencer.
//
//   channel   direction  handshake            content
//   req_      in         req_valid/req_ready  action, altitude, time, phase
//   rsp_      out        rsp_valid/rsp_ready  phase, chosen, peak, pulses
//   csr_      in         csr_we               register index and data
//
// A word that triggers a window decision passes PREP, SCAN, DRAIN and COMMIT
// from accept to result: the search reads one stored sample per cycle from the window
// memory. Commands and filling samples pass PREP and COMMIT.
// One word is in flight at a time; the next is taken while the result waits.
// A stalled result holds the commit step. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module descent_phase_sequencer #(
   parameter int WINDOW = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dps_pkg::ACT_W-1:0]         req_action,
   input  logic signed [dps_pkg::ALT_W-1:0]  req_altitude_cm,
   input  logic [dps_pkg::MS_W-1:0]          req_now_ms,
   input  logic [dps_pkg::PHASE_W-1:0]       req_forced_phase,
   input  logic                              csr_we,
   input  logic [dps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dps_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dps_pkg::PHASE_W-1:0]       rsp_phase,
   output logic                              rsp_evaluated,
   output logic signed [dps_pkg::ALT_W-1:0]  rsp_chosen_cm,
   output logic signed [dps_pkg::ALT_W-1:0]  rsp_peak_cm,
   output logic                              rsp_deploy_chute,
   output logic                              rsp_release_payload,
   output logic                              rsp_toggle_camera,
   output logic                              rsp_payload_off,
   output logic                              rsp_stop_telemetry,
   output logic                              rsp_buzz
);
   import dps_pkg::*;

   dps_cmd_type  cmd;
   dps_stat_type stat;

   dps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dps_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_altitude_cm     (req_altitude_cm),
      .req_now_ms          (req_now_ms),
      .req_forced_phase    (req_forced_phase),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_phase           (rsp_phase),
      .rsp_evaluated       (rsp_evaluated),
      .rsp_chosen_cm       (rsp_chosen_cm),
      .rsp_peak_cm         (rsp_peak_cm),
      .rsp_deploy_chute    (rsp_deploy_chute),
      .rsp_release_payload (rsp_release_payload),
      .rsp_toggle_camera   (rsp_toggle_camera),
      .rsp_payload_off     (rsp_payload_off),
      .rsp_stop_telemetry  (rsp_stop_telemetry),
      .rsp_buzz            (rsp_buzz)
   );

   `DPS_ASSERT_IMPL(a_chosen_idle, clock, reset, rsp_valid && !rsp_evaluated, rsp_chosen_cm == '0, "chosen set without decision")
   `DPS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second word taken while busy")
   `DPS_ASSERT_IMPL(a_landed_pulses, clock, reset, rsp_valid && (rsp_buzz || rsp_stop_telemetry), rsp_phase == PH_LANDED, "landed pulse outside landed phase")
   `DPS_ASSERT_IMPL(a_pulse_needs_eval, clock, reset, rsp_valid && (rsp_deploy_chute || rsp_release_payload || rsp_toggle_camera || rsp_payload_off), rsp_evaluated, "action pulse without decision")

endmodule
